// ===== hw/rtl/hsvr_pkg.sv =====
// ----------------------------------------------------------------------------
// hsvr_pkg: shared types and constants for the HSV to RGB converter
// Fixed-point formats, hue turn constants and the hue split record.
// ----------------------------------------------------------------------------
package hsvr_pkg;

  localparam int unsigned ChanW  = 17;  // s, v and rgb: 16 fraction bits
  localparam int unsigned HueW   = 17;  // signed, 12 fraction bits
  localparam int unsigned FracW  = 12;
  localparam int unsigned SectW  = 3;

  localparam logic [ChanW-1:0]   ChanOne  = 17'd65536;
  localparam logic [FracW:0]     FracOne  = 13'd4096;
  localparam logic signed [17:0] HueTurn  = 18'sd24576;
  localparam logic signed [17:0] HueLast  = 18'sd24575;

  typedef enum logic [SectW-1:0] {
    SecRedYel   = 3'd0,
    SecYelGrn   = 3'd1,
    SecGrnCyan  = 3'd2,
    SecCyanBlue = 3'd3,
    SecBlueMag  = 3'd4,
    SecMagRed   = 3'd5
  } sector_e;

  typedef struct packed {
    sector_e          sector;
    logic [FracW-1:0] frac;
  } hue_split_t;

endpackage

// ===== hw/rtl/hsvr_hue_split.sv =====
// ----------------------------------------------------------------------------
// hsvr_hue_split: hue wrap, clamp and sector split
// Wraps the hue once into the turn, clamps what is left outside, and splits
// it into the sector number and the 12-bit fraction inside the sector.
// ----------------------------------------------------------------------------
module hsvr_hue_split (
  input  logic signed [hsvr_pkg::HueW-1:0] hue_i,
  output hsvr_pkg::hue_split_t             split_o
);
  import hsvr_pkg::*;

  logic signed [17:0] h_ext;
  logic signed [17:0] h_up;
  logic signed [17:0] h_wrap;
  logic signed [17:0] h_clamp;

  always_comb begin
    h_ext  = {hue_i[HueW-1], hue_i};
    h_up   = (h_ext < 18'sd0) ? h_ext + HueTurn : h_ext;
    h_wrap = (h_up >= HueTurn) ? h_up - HueTurn : h_up;
    if (h_wrap < 18'sd0) begin
      h_clamp = 18'sd0;
    end else if (h_wrap > HueLast) begin
      h_clamp = HueLast;
    end else begin
      h_clamp = h_wrap;
    end
    split_o.sector = sector_e'(h_clamp[14:12]);
    split_o.frac   = h_clamp[FracW-1:0];
  end

endmodule

// ===== hw/rtl/hsv_to_rgb_hexcone.sv =====
// ----------------------------------------------------------------------------
// hsv_to_rgb_hexcone: HSV to RGB pixel converter, hexcone model
// Four-stage pipeline: hue split, saturation scaling, p/q/t products, select.
// ----------------------------------------------------------------------------
// Takes one pixel per clock while the output side is not stalled and
// returns its RGB value through the stage registers. Each stage holds one item
// and has its own valid bit; a stage takes a new item whenever it is empty
// or its item moves on, so bubbles close up under back-pressure. The two
// multiply stages (s*f, then v*(1-x) for p, q and t) are each followed by
// a register. Hue is signed with 12 fraction bits (4096 per
// sector) and is wrapped once into the turn, then clamped; saturation is
// clamped to 1.0; zero saturation yields gray (r = g = b = v).
module hsv_to_rgb_hexcone (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [hsvr_pkg::HueW-1:0]  hue_i,
  input  logic        [hsvr_pkg::ChanW-1:0] saturation_i,
  input  logic        [hsvr_pkg::ChanW-1:0] brightness_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic        [hsvr_pkg::ChanW-1:0] red_o,
  output logic        [hsvr_pkg::ChanW-1:0] green_o,
  output logic        [hsvr_pkg::ChanW-1:0] blue_o
);
  import hsvr_pkg::*;

  // stage handshake
  logic valid1_q, valid2_q, valid3_q, valid4_q;
  logic valid1_d, valid2_d, valid3_d, valid4_d;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4 = !valid4_q || out_ready_i;
  assign rdy3 = !valid3_q || rdy4;
  assign rdy2 = !valid2_q || rdy3;
  assign rdy1 = !valid1_q || rdy2;

  assign valid1_d = rdy1 ? in_valid_i : valid1_q;
  assign valid2_d = rdy2 ? valid1_q   : valid2_q;
  assign valid3_d = rdy3 ? valid2_q   : valid3_q;
  assign valid4_d = rdy4 ? valid3_q   : valid4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid1_q <= 1'b0;
      valid2_q <= 1'b0;
      valid3_q <= 1'b0;
      valid4_q <= 1'b0;
    end else begin
      valid1_q <= valid1_d;
      valid2_q <= valid2_d;
      valid3_q <= valid3_d;
      valid4_q <= valid4_d;
    end
  end

  assign in_ready_o  = rdy1;
  assign out_valid_o = valid4_q;

  // stage 1: hue split, saturation clamp
  hue_split_t       split;
  hue_split_t       split1_q;
  logic [ChanW-1:0] sat1_d, sat1_q, val1_q;
  logic             gray1_d, gray1_q;

  hsvr_hue_split u_hue_split (
    .hue_i   (hue_i),
    .split_o (split)
  );

  assign sat1_d  = (saturation_i > ChanOne) ? ChanOne : saturation_i;
  assign gray1_d = (saturation_i == '0);

  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) begin
      split1_q <= split;
      sat1_q   <= sat1_d;
      val1_q   <= brightness_i;
      gray1_q  <= gray1_d;
    end
  end

  // stage 2: s*f and s*(1-f), 16 fraction bits, truncated
  logic [28:0]      prod_sf;
  logic [29:0]      prod_sfc;
  logic [ChanW-1:0] sf2_q, sfc2_q, sat2_q, val2_q;
  sector_e          sector2_q;
  logic             gray2_q;

  assign prod_sf  = 29'(sat1_q) * 29'(split1_q.frac);
  assign prod_sfc = 30'(sat1_q) * 30'(FracOne - {1'b0, split1_q.frac});

  always_ff @(posedge clk_i) begin
    if (rdy2 && valid1_q) begin
      sf2_q     <= prod_sf[28:12];
      sfc2_q    <= prod_sfc[28:12];
      sat2_q    <= sat1_q;
      val2_q    <= val1_q;
      sector2_q <= split1_q.sector;
      gray2_q   <= gray1_q;
    end
  end

  // stage 3: p, q, t = v * (1 - x), truncated
  logic [ChanW-1:0] om_s, om_sf, om_sfc;
  logic [33:0]      prod_p, prod_q, prod_t;
  logic [ChanW-1:0] p3_q, q3_q, t3_q, val3_q;
  sector_e          sector3_q;
  logic             gray3_q;

  assign om_s   = ChanOne - sat2_q;
  assign om_sf  = ChanOne - sf2_q;
  assign om_sfc = ChanOne - sfc2_q;

  assign prod_p = 34'(val2_q) * 34'(om_s);
  assign prod_q = 34'(val2_q) * 34'(om_sf);
  assign prod_t = 34'(val2_q) * 34'(om_sfc);

  always_ff @(posedge clk_i) begin
    if (rdy3 && valid2_q) begin
      p3_q      <= prod_p[32:16];
      q3_q      <= prod_q[32:16];
      t3_q      <= prod_t[32:16];
      val3_q    <= val2_q;
      sector3_q <= sector2_q;
      gray3_q   <= gray2_q;
    end
  end

  // stage 4: sector select into the output register
  logic [ChanW-1:0] red_d, green_d, blue_d;
  logic [ChanW-1:0] red_q, green_q, blue_q;

  always_comb begin
    if (gray3_q) begin
      red_d   = val3_q;
      green_d = val3_q;
      blue_d  = val3_q;
    end else begin
      case (sector3_q)
        SecRedYel: begin
          red_d = val3_q; green_d = t3_q;   blue_d = p3_q;
        end
        SecYelGrn: begin
          red_d = q3_q;   green_d = val3_q; blue_d = p3_q;
        end
        SecGrnCyan: begin
          red_d = p3_q;   green_d = val3_q; blue_d = t3_q;
        end
        SecCyanBlue: begin
          red_d = p3_q;   green_d = q3_q;   blue_d = val3_q;
        end
        SecBlueMag: begin
          red_d = t3_q;   green_d = p3_q;   blue_d = val3_q;
        end
        default: begin
          red_d = val3_q; green_d = p3_q;   blue_d = q3_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy4 && valid3_q) begin
      red_q   <= red_d;
      green_q <= green_d;
      blue_q  <= blue_d;
    end
  end

  assign red_o   = red_q;
  assign green_o = green_q;
  assign blue_o  = blue_q;

endmodule
